### hdl/nkms_pkg.sv
// ---------------------------------------------------------------------------
// nkms_pkg: shared types and constants
// Widths, mode codes, entry layout and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none
package nkms_pkg;
  localparam int CAPACITY    = 64;
  localparam int MAX_RESULTS = 64;
  localparam int MCAP        = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
  localparam int AW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int KW          = 7;
  localparam int LW          = (CW > KW) ? CW : KW;
  localparam int RW          = 6;

  localparam int IN_DW  = 152;
  localparam int OUT_DW = 152;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_FINAL = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // One stored record
  typedef struct packed {
    logic        seen;
    logic [7:0]  version;
    logic [31:0] flags;
    logic [7:0]  kind;
    logic [31:0] msg;
    logic [31:0] user;
    logic [31:0] date;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic add_init;
    logic rd_prev;
    logic wr_new;
    logic wr_shift;
    logic fin_init;
    logic out_load;
    logic out_empty;
    logic fin_next;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic idx_zero;
    logic rd_ge;
    logic cnt_zero;
    logic out_last;
  } sts_t;
endpackage
`default_nettype wire

### hdl/nkms_ram.sv
// ---------------------------------------------------------------------------
// nkms_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module nkms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/nkms_ctrl.sv
// ---------------------------------------------------------------------------
// nkms_ctrl: sequencer for add, finalize and clear
// Walks insertion shifts and the emit run one entry at a time.
// ---------------------------------------------------------------------------
`default_nettype none
module nkms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [1:0]     mode,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output nkms_pkg::cmd_t      cmd,
  input  wire nkms_pkg::sts_t sts
);
  import nkms_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ADD_INIT = 4'd1;
  localparam logic [3:0] ST_CHK_RD   = 4'd2;
  localparam logic [3:0] ST_CHK_CMP  = 4'd3;
  localparam logic [3:0] ST_SH_TEST  = 4'd4;
  localparam logic [3:0] ST_SH_CMP   = 4'd5;
  localparam logic [3:0] ST_FIN_INIT = 4'd6;
  localparam logic [3:0] ST_FIN_RD   = 4'd7;
  localparam logic [3:0] ST_FIN_LD   = 4'd8;
  localparam logic [3:0] ST_FIN_OUT  = 4'd9;

  logic [3:0] state, state_next;
  logic       acc;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_FIN_OUT);
  assign acc      = s_tvalid && s_tready;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd.capture = 1'b1;
          unique case (mode)
            MODE_ADD:   state_next = ST_ADD_INIT;
            MODE_FINAL: state_next = ST_FIN_INIT;
            MODE_CLEAR: cmd.clear = 1'b1;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_INIT: begin
        cmd.add_init = 1'b1;
        state_next   = sts.full ? ST_CHK_RD : ST_SH_TEST;
      end
      ST_CHK_RD: begin
        state_next = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        state_next = sts.rd_ge ? ST_IDLE : ST_SH_TEST;
      end
      ST_SH_TEST: begin
        if (sts.idx_zero) begin
          cmd.wr_new = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ST_SH_CMP;
        end
      end
      ST_SH_CMP: begin
        if (sts.rd_ge) begin
          cmd.wr_new = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.wr_shift = 1'b1;
          state_next   = ST_SH_TEST;
        end
      end
      ST_FIN_INIT: begin
        cmd.fin_init = 1'b1;
        state_next   = ST_FIN_RD;
      end
      ST_FIN_RD: begin
        if (sts.cnt_zero) begin
          cmd.out_empty = 1'b1;
          state_next    = ST_FIN_OUT;
        end else begin
          state_next = ST_FIN_LD;
        end
      end
      ST_FIN_LD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        if (m_tready) begin
          if (sts.out_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.fin_next = 1'b1;
            state_next   = ST_FIN_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/nkms_dp.sv
// ---------------------------------------------------------------------------
// nkms_dp: table datapath
// Entry RAM, fill count, walk index, held item and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module nkms_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [nkms_pkg::KW-1:0]      keep_count,
  input  wire logic [nkms_pkg::IN_DW-1:0]   in_data,
  input  wire nkms_pkg::cmd_t               cmd,
  output nkms_pkg::sts_t                    sts,
  output logic      [nkms_pkg::OUT_DW-1:0]  out_data,
  output logic                              out_valid,
  output logic                              out_last
);
  import nkms_pkg::*;

  entry_t         rec;
  entry_t         rd_entry;
  logic [EW-1:0]  rdata;
  logic [EW-1:0]  wdata;
  logic [CW-1:0]  count;
  logic [CW-1:0]  lim;
  logic [CW-1:0]  n_eff;
  logic [CW-1:0]  m_eff;
  logic [CW-1:0]  idx_inc;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  raddr;
  logic           we;
  logic           last_now;
  logic [LW-1:0]  kc_ext;

  // Work out the limit
  assign kc_ext = LW'(keep_count);
  assign lim    = (keep_count == '0 || kc_ext > LW'(CAPACITY)) ? CW'(CAPACITY)
                                                               : CW'(keep_count);
  assign n_eff  = (count < lim) ? count : lim;
  assign m_eff  = (count > CW'(MCAP)) ? CW'(MCAP) : count;
  assign idx_inc  = CW'(idx) + CW'(1);
  assign last_now = (idx_inc == m_eff);

  assign rd_entry = entry_t'(rdata);
  assign raddr    = cmd.rd_prev ? idx - AW'(1) : idx;
  assign we       = cmd.wr_new || cmd.wr_shift;
  assign wdata    = cmd.wr_new ? EW'(rec) : rdata;

  nkms_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.full     = (count >= lim);
  assign sts.idx_zero = (idx == '0);
  assign sts.rd_ge    = (rd_entry.date >= rec.date);
  assign sts.cnt_zero = (count == '0);
  assign sts.out_last = out_last;

  // Hold the item under work
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rec.user    <= in_data[31:0];
      rec.msg     <= in_data[63:32];
      rec.date    <= in_data[95:64];
      rec.kind    <= in_data[103:96];
      rec.flags   <= in_data[135:104];
      rec.version <= in_data[143:136];
      rec.seen    <= in_data[144];
    end
  end

  // Track fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.add_init || cmd.fin_init) begin
      count <= n_eff;
    end else if (cmd.wr_new) begin
      count <= (count < lim) ? count + CW'(1) : lim;
    end
  end

  // Advance the walk index
  always_ff @(posedge clk) begin
    if (cmd.add_init) begin
      idx <= (count >= lim) ? AW'(lim - CW'(1)) : AW'(count);
    end else if (cmd.wr_shift) begin
      idx <= idx - AW'(1);
    end else if (cmd.fin_init) begin
      idx <= '0;
    end else if (cmd.fin_next) begin
      idx <= idx + AW'(1);
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data  <= {1'b0, RW'(idx), rd_entry.seen, rd_entry.version, rd_entry.flags,
                    rd_entry.kind, rd_entry.date, rd_entry.msg, rd_entry.user};
      out_valid <= 1'b1;
      out_last  <= last_now;
    end else if (cmd.out_empty) begin
      out_data  <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b1;
    end
  end
endmodule
`default_nettype wire

### hdl/newest_k_message_selector.sv
// ---------------------------------------------------------------------------
// newest_k_message_selector: keeps the K newest message records by date
// Sorted insertion into an entry RAM; finalize streams the list newest first.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: mode; tdata: record fields
//  m_axis    out        tdata: entry fields and rank; tuser: entry_valid; tlast
//  apb       in/out     keep_count at address 0
//
//  Add: shifts entries up from the tail one per step until one at least as
//  new is met; when full, a record not newer than the tail is rejected.
//  Finalize: after setup, each entry is read, loaded into the output register
//  and held until the sink takes it; an empty table gives one result with
//  entry_valid low and tlast set. A stalled result holds in the output register.
//  Clear needs no walk. Input is taken only while no operation is running.
//  Synchronous reset empties the table; entry RAM contents stay undefined.
`default_nettype none
module newest_k_message_selector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [31:0] user_id, [63:32] msg_id, [95:64] msg_date, [103:96] msg_type,
  // [135:104] msg_flags, [143:136] msg_version, [144] msg_seen
  input  wire logic [nkms_pkg::IN_DW-1:0]    s_tdata,
  // [1:0] mode
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [31:0] out_user_id, [63:32] out_msg_id, [95:64] out_date, [103:96] out_type,
  // [135:104] out_flags, [143:136] out_version, [144] out_seen, [150:145] rank
  output logic      [nkms_pkg::OUT_DW-1:0]   m_tdata,
  // [0] entry_valid
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import nkms_pkg::*;

  logic [KW-1:0] keep_count;
  cmd_t          cmd;
  sts_t          sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(keep_count) : 32'd0;

  // Write the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      keep_count <= pwdata[KW-1:0];
    end
  end

  nkms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  nkms_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .keep_count (keep_count),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (m_tdata),
    .out_valid  (m_tuser),
    .out_last   (m_tlast)
  );
endmodule
`default_nettype wire

### bench/tb_newest_k_message_selector.sv
// ---------------------------------------------------------------------------
// tb_newest_k_message_selector: self-checking bench for the newest-K selector
// Drives add, finalize and clear transactions over the stream input, sets the
// keep count over APB between phases, and checks every emitted entry against
// a sorted-table predictor kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_newest_k_message_selector;
  import nkms_pkg::*;

  typedef struct packed {
    logic [31:0] user;
    logic [31:0] msg;
    logic [31:0] date;
    logic [7:0]  kind;
    logic [31:0] flags;
    logic [7:0]  version;
    logic        seen;
  } rec_t;

  typedef struct packed {
    rec_t       rec;
    logic [5:0] rank;
    logic       valid;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic [1:0] mode;
    rec_t       rec;
    logic       chk;     // directed row with a typed-in result
    emit_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = MODE_CLEAR;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_KEEP = 3'd0;

  // Predictor state
  rec_t table_q[$];
  int unsigned keep_reg;
  emit_t pending_q[$];
  int errors;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;

  newest_k_message_selector DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic int unsigned table_limit();
    if (keep_reg == 0 || keep_reg > CAPACITY) return CAPACITY;
    return keep_reg;
  endfunction

  // Insert behind equal dates; reject when full and not strictly newer
  function automatic void insert_record(input rec_t r);
    int unsigned lim;
    int unsigned p;
    lim = table_limit();
    while (table_q.size() > lim) void'(table_q.pop_back());
    p = 0;
    while (p < table_q.size() && table_q[p].date >= r.date) p++;
    if (table_q.size() >= lim && p >= lim) return;
    table_q.insert(p, r);
    if (table_q.size() > lim) void'(table_q.pop_back());
  endfunction

  function automatic void predict(input logic [1:0] mode, input rec_t r);
    emit_t e;
    int unsigned lim;
    case (mode)
      MODE_ADD: insert_record(r);
      MODE_CLEAR: table_q.delete();
      MODE_FINAL: begin
        lim = table_limit();
        while (table_q.size() > lim) void'(table_q.pop_back());
        if (table_q.size() == 0) begin
          e = '0;
          e.last = 1'b1;
          pending_q.insert(pending_q.size(), e);
        end else begin
          for (int k = 0; k < table_q.size() && k < MAX_RESULTS; k++) begin
            e.rec = table_q[k];
            e.rank = k[5:0];
            e.valid = 1'b1;
            e.last = (k + 1 == table_q.size()) || (k + 1 == MAX_RESULTS);
            pending_q.insert(pending_q.size(), e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [IN_DW-1:0] pack_rec(input rec_t r);
    logic [IN_DW-1:0] d;
    d = '0;
    d[31:0] = r.user;
    d[63:32] = r.msg;
    d[95:64] = r.date;
    d[103:96] = r.kind;
    d[135:104] = r.flags;
    d[143:136] = r.version;
    d[144] = r.seen;
    return d;
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    emit_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[63:0], 0);
      end else begin
        e = pending_q.pop_front();
        if (e.valid) begin
          if (m_tdata[31:0] !== e.rec.user) report_mismatch("user", m_tdata[31:0], e.rec.user);
          if (m_tdata[63:32] !== e.rec.msg) report_mismatch("msg", m_tdata[63:32], e.rec.msg);
          if (m_tdata[95:64] !== e.rec.date) report_mismatch("date", m_tdata[95:64], e.rec.date);
          if (m_tdata[103:96] !== e.rec.kind) report_mismatch("type", m_tdata[103:96], e.rec.kind);
          if (m_tdata[135:104] !== e.rec.flags)
            report_mismatch("flags", m_tdata[135:104], e.rec.flags);
          if (m_tdata[143:136] !== e.rec.version)
            report_mismatch("version", m_tdata[143:136], e.rec.version);
          if (m_tdata[144] !== e.rec.seen) report_mismatch("seen", m_tdata[144], e.rec.seen);
        end
        if (m_tdata[150:145] !== e.rank) report_mismatch("rank", m_tdata[150:145], e.rank);
        if (m_tuser !== e.valid) report_mismatch("entry_valid", m_tuser, e.valid);
        if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one transaction; tvalid stays up until the next idle or drain
  task automatic send(input logic [1:0] mode, input rec_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= pack_rec(r);
    do @(posedge clk); while (!s_tready);
    predict(mode, r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_keep(input int unsigned v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_KEEP; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    keep_reg = v & 32'h7F;
  endtask

  function automatic rec_t rand_rec(input int date_span);
    rec_t r;
    r.user = $urandom; r.msg = $urandom;
    r.date = (date_span == 0) ? $urandom : $urandom_range(date_span);
    r.kind = $urandom; r.flags = $urandom;
    r.version = $urandom; r.seen = $urandom;
    return r;
  endfunction

  // Random mix: mostly adds, some finalizes, clears and mode 3; ends with a finalize
  task automatic random_phase(input int items);
    int n;
    int pick;
    n = 0;
    while (n < items) begin
      pick = $urandom_range(99);
      if (pick < 70) send(MODE_ADD, rand_rec($urandom_range(1) ? 40 : 0));
      else if (pick < 85) send(MODE_FINAL, rand_rec(0));
      else if (pick < 93) send(MODE_CLEAR, rand_rec(0));
      else send(2'd3, rand_rec(0));
      n++;
    end
    send(MODE_FINAL, rand_rec(0));
  endtask

  row_t rows[$];
  row_t rw;
  rec_t r0;
  rec_t rmax;

  initial begin
    errors = 0;
    keep_reg = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty finalize, extremes, ties, mode 3
    r0 = '0;
    rmax = '1;
    rw = '0; rw.mode = MODE_FINAL; rw.chk = 1; rw.want.last = 1; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_ADD; rw.rec = r0; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_FINAL; rw.chk = 1; rw.want.valid = 1; rw.want.last = 1;
    rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_ADD; rw.rec = rmax; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_ADD; rw.rec = rmax; rw.rec.msg = 32'h1; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_ADD; rw.rec = r0; rw.rec.msg = 32'h2; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = 2'd3; rw.rec = rmax; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_FINAL; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_CLEAR; rows.insert(rows.size(), rw);
    rw = '0; rw.mode = MODE_FINAL; rw.chk = 1; rw.want.last = 1; rows.insert(rows.size(), rw);
    foreach (rows[i]) begin
      if (rows[i].chk) begin
        // typed-in result must agree with the predictor
        predict(rows[i].mode, rows[i].rec);
        if (pending_q.size() != 1 || pending_q[0] !== rows[i].want)
          report_mismatch("directed row", i, 0);
        pending_q.delete();
        pending_q.insert(pending_q.size(), rows[i].want);
        s_tvalid <= 1'b1; s_tuser <= rows[i].mode; s_tdata <= pack_rec(rows[i].rec);
        do @(posedge clk); while (!s_tready);
      end else begin
        send(rows[i].mode, rows[i].rec);
      end
    end
    drain();

    // Limit 1, then lowered while full
    write_keep(1);
    for (int i = 0; i < 5; i++) send(MODE_ADD, rand_rec(10));
    send(MODE_FINAL, r0);
    drain();
    write_keep(0);
    for (int i = 0; i < 70; i++) send(MODE_ADD, rand_rec(0));
    send(MODE_FINAL, r0);
    drain();
    write_keep(3);
    send(MODE_ADD, rand_rec(0));
    send(MODE_FINAL, r0);
    drain();
    write_keep(7'h7F);
    send(MODE_FINAL, r0);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 4; i++) send(MODE_FINAL, r0);
      end
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    // Idle profiles across keep settings
    write_keep(5);
    send_idle_pct = 13; recv_idle_pct = 62;
    random_phase(100);
    drain();
    write_keep(64);
    send_idle_pct = 62; recv_idle_pct = 13;
    random_phase(100);
    drain();
    write_keep(2);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(110);
    drain();

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
